[rtl/sols_pkg.sv]
// Shared types and constants for the self-organizing list search block.
// Used by sols_ctrl, sols_dp and self_organizing_list_search; no dependencies.
`default_nettype none

package sols_pkg;

    localparam int KEY_W  = 32;
    localparam int POS_W  = 6;
    localparam int CMD_W  = 2;
    localparam int MODE_W = 2;

    // Input command codes; the fourth code is unused and gives an all-zero result.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // Reorder modes; the fourth code behaves like MODE_NONE.
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FRONT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWAP  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FILL
    } t_state;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_TAG,
        POS_HIT,
        POS_LO
    } t_pos_sel;

    typedef struct packed {
        logic     clear;
        logic     append;
        logic     load_key;
        logic     scan_start;
        logic     scan_run;
        logic     shift_start;
        logic     lo_prev;
        logic     shift_run;
        logic     fill;
        logic     emit;
        logic     emit_found;
        logic     emit_full;
        t_pos_sel pos_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic scan_miss;
        logic hit_front;
        logic shift_last;
        logic full;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/sols_ctrl.sv]
// Sequencer for the self-organizing list search block: command decode,
// scan / shift / fill phases and the reorder mode register. Uses sols_pkg.
`default_nettype none

module sols_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    input  wire logic [sols_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic                         i_cfg_we,
    input  wire logic [sols_pkg::MODE_W-1:0]  i_cfg_wdata,
    input  wire sols_pkg::t_dp_status         i_status,
    output sols_pkg::t_dp_cmd                 o_cmd,
    output logic                              busy
);

    sols_pkg::t_state            r_state;
    sols_pkg::t_state            n_state;
    logic [sols_pkg::MODE_W-1:0] r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sols_pkg::S_IDLE;
            r_mode  <= sols_pkg::MODE_NONE;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            sols_pkg::S_IDLE: begin
                if (start) begin
                    unique case (i_cmd)
                        sols_pkg::CMD_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            o_cmd.emit  = 1'b1;
                        end
                        sols_pkg::CMD_APPEND: begin
                            o_cmd.emit = 1'b1;
                            if (i_status.full) begin
                                o_cmd.emit_full = 1'b1;
                            end else begin
                                o_cmd.append = 1'b1;
                            end
                        end
                        sols_pkg::CMD_SEARCH: begin
                            o_cmd.load_key   = 1'b1;
                            o_cmd.scan_start = 1'b1;
                            n_state          = sols_pkg::S_SCAN;
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            sols_pkg::S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.hit) begin
                    if (r_mode == sols_pkg::MODE_FRONT && !i_status.hit_front) begin
                        o_cmd.shift_start = 1'b1;
                        n_state           = sols_pkg::S_SHIFT;
                    end else if (r_mode == sols_pkg::MODE_SWAP && !i_status.hit_front) begin
                        o_cmd.shift_start = 1'b1;
                        o_cmd.lo_prev     = 1'b1;
                        n_state           = sols_pkg::S_SHIFT;
                    end else begin
                        o_cmd.emit       = 1'b1;
                        o_cmd.emit_found = 1'b1;
                        o_cmd.pos_sel    = sols_pkg::POS_TAG;
                        n_state          = sols_pkg::S_IDLE;
                    end
                end else if (i_status.scan_miss) begin
                    o_cmd.emit = 1'b1;
                    n_state    = sols_pkg::S_IDLE;
                end
            end
            sols_pkg::S_SHIFT: begin
                o_cmd.shift_run = 1'b1;
                if (i_status.shift_last) begin
                    n_state = sols_pkg::S_FILL;
                end
            end
            sols_pkg::S_FILL: begin
                // The hit key equals the search key, so the key register refills the hole.
                o_cmd.fill       = 1'b1;
                o_cmd.emit       = 1'b1;
                o_cmd.emit_found = 1'b1;
                o_cmd.pos_sel    = (r_mode == sols_pkg::MODE_FRONT) ? sols_pkg::POS_HIT
                                                                     : sols_pkg::POS_LO;
                n_state          = sols_pkg::S_IDLE;
            end
            default: begin
                n_state = sols_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != sols_pkg::S_IDLE);

    a_search_enters_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == sols_pkg::CMD_SEARCH) |=> (r_state == sols_pkg::S_SCAN))
        else $error("search transfer did not start a scan");

    a_fill_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sols_pkg::S_FILL) |=> (r_state == sols_pkg::S_IDLE))
        else $error("fill phase did not finish the search");

    a_plain_hit_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sols_pkg::S_SCAN && i_status.hit && r_mode == sols_pkg::MODE_NONE)
        |-> (o_cmd.emit && o_cmd.emit_found && !o_cmd.shift_start))
        else $error("hit without reordering did not report at once");

endmodule

`default_nettype wire

[rtl/sols_dp.sv]
// Datapath of the self-organizing list search block: key memory, fill count,
// scan and shift address counters, compare and result registers. Uses sols_pkg.
`default_nettype none

module sols_dp #(
    parameter int DEPTH = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic signed [sols_pkg::KEY_W-1:0]  i_key,
    input  wire sols_pkg::t_dp_cmd                  i_cmd,
    output sols_pkg::t_dp_status                    o_status,
    output logic                                    o_valid,
    output logic                                    o_found,
    output logic [sols_pkg::POS_W-1:0]              o_position,
    output logic                                    o_table_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [sols_pkg::KEY_W-1:0] r_mem [DEPTH];

    logic [CW-1:0]              r_count;
    logic signed [sols_pkg::KEY_W-1:0] r_key;
    logic [AW-1:0]              r_rd_idx;
    logic                       r_issue_on;
    logic                       r_rd_vld;
    logic [AW-1:0]              r_rd_tag;
    logic [sols_pkg::KEY_W-1:0] r_rd_data;
    logic [AW-1:0]              r_hit;
    logic [AW-1:0]              r_lo;
    logic                       r_valid;
    logic                       r_found;
    logic                       r_full;
    logic [sols_pkg::POS_W-1:0] r_pos;

    logic                       rd_en;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [sols_pkg::KEY_W-1:0] wr_data;
    logic [CW-1:0]              count_m1;
    logic [AW-1:0]              last_idx;
    logic                       match;
    logic [AW-1:0]              pos_idx;

    assign count_m1 = r_count - CW'(1);
    assign last_idx = count_m1[AW-1:0];
    assign match    = (r_rd_data == r_key);
    assign rd_en    = r_issue_on && (i_cmd.scan_run || i_cmd.shift_run);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        priority if (i_cmd.append) begin
            wr_en   = 1'b1;
            wr_addr = r_count[AW-1:0];
            wr_data = i_key;
        end else if (i_cmd.fill) begin
            wr_en   = 1'b1;
            wr_addr = r_lo;
            wr_data = r_key;
        end else if (i_cmd.shift_run && r_rd_vld) begin
            // Each entry read on the way down moves one place toward the back.
            wr_en   = 1'b1;
            wr_addr = r_rd_tag + AW'(1);
            wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx];
            r_rd_tag  <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_issue_on <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_idx   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end

            if (i_cmd.scan_start) begin
                r_rd_idx   <= '0;
                r_issue_on <= (r_count != '0);
                r_rd_vld   <= 1'b0;
            end else if (i_cmd.shift_start) begin
                // Reads still in flight from the scan are dropped here.
                r_rd_idx   <= r_rd_tag - AW'(1);
                r_issue_on <= 1'b1;
                r_rd_vld   <= 1'b0;
            end else begin
                r_rd_vld <= rd_en;
                if (rd_en && i_cmd.scan_run) begin
                    if (r_rd_idx == last_idx) begin
                        r_issue_on <= 1'b0;
                    end else begin
                        r_rd_idx <= r_rd_idx + AW'(1);
                    end
                end else if (rd_en) begin
                    if (r_rd_idx == r_lo) begin
                        r_issue_on <= 1'b0;
                    end else begin
                        r_rd_idx <= r_rd_idx - AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key <= i_key;
        end
        if (i_cmd.shift_start) begin
            r_hit <= r_rd_tag;
            r_lo  <= i_cmd.lo_prev ? (r_rd_tag - AW'(1)) : '0;
        end
    end

    always_comb begin
        unique case (i_cmd.pos_sel)
            sols_pkg::POS_ZERO: pos_idx = '0;
            sols_pkg::POS_TAG:  pos_idx = r_rd_tag;
            sols_pkg::POS_HIT:  pos_idx = r_hit;
            sols_pkg::POS_LO:   pos_idx = r_lo;
            default:            pos_idx = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_found <= i_cmd.emit_found;
            r_full  <= i_cmd.emit_full;
            r_pos   <= sols_pkg::POS_W'(pos_idx);
        end
    end

    assign o_status.hit        = r_rd_vld && match;
    assign o_status.scan_miss  = (r_count == '0) ||
                                 (r_rd_vld && !match && r_rd_tag == last_idx);
    assign o_status.hit_front  = (r_rd_tag == '0);
    assign o_status.shift_last = r_rd_vld && (r_rd_tag == r_lo);
    assign o_status.full       = (r_count == CW'(DEPTH));

    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_position   = r_pos;
    assign o_table_full = r_full;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond table depth");

    a_shift_below_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift_run && r_rd_vld) |-> (r_rd_tag < r_hit && r_rd_tag >= r_lo))
        else $error("shift touched an entry outside the moved range");

    a_no_append_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (r_count < CW'(DEPTH)))
        else $error("append written into a full table");

endmodule

`default_nettype wire

[rtl/self_organizing_list_search.sv]
// Self-organizing list search: clear, append and search over a table of keys.
// Clear and append: result strobe in the cycle after the transfer; busy stays low, so a new item can follow.
// Search: a scan from the front, one memory read per cycle, that stops at the first hit or after the last
// entry; move-to-front and transpose then add a shift phase and a fill. Busy holds off new items meanwhile.
// Results cannot be stalled. Reset clears the fill count and sets reorder mode to none;
// table contents are left undefined and need no clearing pass.
`default_nettype none

module self_organizing_list_search #(
    parameter int DEPTH = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [sols_pkg::CMD_W-1:0]         i_cmd,
    input  wire logic signed [sols_pkg::KEY_W-1:0]  i_key,
    input  wire logic                               i_cfg_we,
    input  wire logic [sols_pkg::MODE_W-1:0]        i_cfg_wdata,
    output logic                                    o_valid,
    output logic                                    o_found,
    output logic [sols_pkg::POS_W-1:0]              o_position,
    output logic                                    o_table_full
);

    sols_pkg::t_dp_cmd    dp_cmd;
    sols_pkg::t_dp_status dp_status;

    sols_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .busy        (busy)
    );

    sols_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (i_key),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_position   (o_position),
        .o_table_full (o_table_full)
    );

endmodule

`default_nettype wire

[sim/tb_self_organizing_list_search.sv]
`timescale 1ns / 100ps
// Testbench for self_organizing_list_search: a directed table, then random phases
// in each reorder mode. Results are checked against a behavioral copy of the key table, or typed directed rows.
// Depends on sols_pkg and the self_organizing_list_search RTL.

module tb_self_organizing_list_search;

    localparam int DEPTH = 64;
    localparam logic [sols_pkg::CMD_W-1:0]  CMD_SPARE  = 2'd3;
    localparam logic [sols_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 65;
    localparam int PHASE_COUNT  = 6;
    localparam int POOL_SIZE    = 8;

    typedef struct packed {
        logic                       found;
        logic [sols_pkg::POS_W-1:0] position;
        logic                       table_full;
    } t_lookup;

    typedef enum logic {ROW_ITEM, ROW_MODE} t_row_kind;

    typedef struct {
        t_row_kind                   kind;
        logic [sols_pkg::CMD_W-1:0]  cmd;
        logic [sols_pkg::KEY_W-1:0]  key;
        logic [sols_pkg::MODE_W-1:0] mode;
        bit                          typed;
        t_lookup                     result;
    } t_dir_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [sols_pkg::CMD_W-1:0]        i_cmd = sols_pkg::CMD_CLEAR;
    logic signed [sols_pkg::KEY_W-1:0] i_key = '0;
    logic                              i_cfg_we = 1'b0;
    logic [sols_pkg::MODE_W-1:0]       i_cfg_wdata = sols_pkg::MODE_NONE;
    logic                              o_valid;
    logic                              o_found;
    logic [sols_pkg::POS_W-1:0]        o_position;
    logic                              o_table_full;

    // Behavioral copy of the block's state.
    logic [sols_pkg::KEY_W-1:0]  key_table [DEPTH];
    int                          key_count = 0;
    logic [sols_pkg::MODE_W-1:0] mode_now = sols_pkg::MODE_NONE;

    t_lookup     lookups_due [$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    t_dir_row    dir_rows [$];
    logic [sols_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    self_organizing_list_search #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_key        (i_key),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_position   (o_position),
        .o_table_full (o_table_full)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_lookup run_lookup(input logic [sols_pkg::CMD_W-1:0] cmd,
                                           input logic [sols_pkg::KEY_W-1:0] key);
        t_lookup                    r;
        int                         hit;
        int                         i;
        logic [sols_pkg::KEY_W-1:0] hit_key;
        r   = '0;
        hit = -1;
        case (cmd)
            sols_pkg::CMD_CLEAR: begin
                key_count = 0;
            end
            sols_pkg::CMD_APPEND: begin
                if (key_count >= DEPTH) begin
                    r.table_full = 1'b1;
                end else begin
                    key_table[key_count] = key;
                    key_count++;
                end
            end
            sols_pkg::CMD_SEARCH: begin
                for (i = 0; i < key_count; i++) begin
                    if (hit < 0 && key_table[i] == key) hit = i;
                end
                if (hit >= 0) begin
                    r.found    = 1'b1;
                    r.position = sols_pkg::POS_W'(hit);
                    hit_key    = key_table[hit];
                    if (mode_now == sols_pkg::MODE_FRONT) begin
                        for (i = hit; i > 0; i--) key_table[i] = key_table[i-1];
                        key_table[0] = hit_key;
                    end else if (mode_now == sols_pkg::MODE_SWAP && hit > 0) begin
                        key_table[hit]   = key_table[hit-1];
                        key_table[hit-1] = hit_key;
                        r.position       = sols_pkg::POS_W'(hit - 1);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_dir_row item_row(input logic [sols_pkg::CMD_W-1:0] cmd,
                                          input logic [sols_pkg::KEY_W-1:0] key,
                                          input bit typed, input t_lookup result);
        t_dir_row row;
        row = '{ROW_ITEM, cmd, key, sols_pkg::MODE_NONE, typed, result};
        return row;
    endfunction

    function automatic t_dir_row mode_row(input logic [sols_pkg::MODE_W-1:0] mode);
        t_dir_row row;
        row = '{ROW_MODE, sols_pkg::CMD_CLEAR, '0, mode, 1'b0, '0};
        return row;
    endfunction

    // One transfer; while idle cycles are on, start drops at random until the block accepts it.
    task automatic send_item(input logic [sols_pkg::CMD_W-1:0] cmd,
                             input logic [sols_pkg::KEY_W-1:0] key,
                             input bit typed, input t_lookup typed_result);
        t_lookup predicted;
        i_cmd <= cmd;
        i_key <= key;
        forever begin
            start <= !(idle_on && $urandom_range(99) < 9);
            @(posedge i_clk);
            if (start && !busy) break;
        end
        predicted = run_lookup(cmd, key);
        lookups_due.push_back(typed ? typed_result : predicted);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (lookups_due.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [sols_pkg::MODE_W-1:0] mode);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        mode_now = mode;
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_lookup got;
        t_lookup want;
        if (i_rst_n && o_valid) begin
            got = '{o_found, o_position, o_table_full};
            if (lookups_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0b position=%0d table_full=%0b",
                             got.found, got.position, got.table_full);
            end else begin
                want = lookups_due.pop_front();
                if (got.found != want.found || got.position != want.position ||
                        got.table_full != want.table_full) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected found=%0b position=%0d table_full=%0b, %s",
                                 want.found, want.position, want.table_full,
                                 $sformatf("got found=%0b position=%0d table_full=%0b",
                                           got.found, got.position, got.table_full));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_self_organizing_list_search: FAIL");
            $finish;
        end
    end

    initial begin
        logic [sols_pkg::MODE_W-1:0] phase_modes [PHASE_COUNT];
        logic [sols_pkg::KEY_W-1:0]  key;
        int                          pick;
        phase_modes = '{sols_pkg::MODE_FRONT, sols_pkg::MODE_SWAP, sols_pkg::MODE_NONE,
                        MODE_SPARE, sols_pkg::MODE_SWAP, sols_pkg::MODE_FRONT};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Mode is left at its reset value for the first rows.
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'd5, 1'b1, '{1'b0, 6'd0, 1'b0}));
        dir_rows.push_back(item_row(CMD_SPARE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 6'd0, 1'b0}));
        dir_rows.push_back(item_row(sols_pkg::CMD_APPEND, 32'h8000_0000, 1'b1,
                                    '{1'b0, 6'd0, 1'b0}));
        dir_rows.push_back(item_row(sols_pkg::CMD_APPEND, 32'h7FFF_FFFF, 1'b1,
                                    '{1'b0, 6'd0, 1'b0}));
        dir_rows.push_back(item_row(sols_pkg::CMD_APPEND, 32'h0000_0000, 1'b1,
                                    '{1'b0, 6'd0, 1'b0}));
        dir_rows.push_back(item_row(sols_pkg::CMD_APPEND, 32'hFFFF_FFFF, 1'b1,
                                    '{1'b0, 6'd0, 1'b0}));
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 1'b1,
                                    '{1'b1, 6'd3, 1'b0}));
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'h8000_0000, 1'b1,
                                    '{1'b1, 6'd0, 1'b0}));
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'h0001_2345, 1'b1,
                                    '{1'b0, 6'd0, 1'b0}));
        dir_rows.push_back(mode_row(sols_pkg::MODE_FRONT));
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'h0000_0000, 1'b0, '0));
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'h0000_0000, 1'b0, '0));
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 1'b0, '0));
        dir_rows.push_back(mode_row(sols_pkg::MODE_SWAP));
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'h7FFF_FFFF, 1'b0, '0));
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 1'b0, '0));
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'h8000_0000, 1'b0, '0));
        dir_rows.push_back(mode_row(MODE_SPARE));
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'h0000_0000, 1'b0, '0));
        dir_rows.push_back(item_row(sols_pkg::CMD_APPEND, 32'h55AA_55AA, 1'b0, '0));
        dir_rows.push_back(item_row(sols_pkg::CMD_CLEAR, 32'h0000_0000, 1'b1,
                                    '{1'b0, 6'd0, 1'b0}));
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 1'b1,
                                    '{1'b0, 6'd0, 1'b0}));
        dir_rows.push_back(item_row(sols_pkg::CMD_APPEND, 32'h0000_0000, 1'b1,
                                    '{1'b0, 6'd0, 1'b0}));
        dir_rows.push_back(item_row(sols_pkg::CMD_SEARCH, 32'h0000_0000, 1'b0, '0));

        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_MODE) begin
                write_mode(dir_rows[n].mode);
            end else begin
                send_item(dir_rows[n].cmd, dir_rows[n].key, dir_rows[n].typed,
                          dir_rows[n].result);
            end
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            write_mode(phase_modes[phase]);
            // The third phase (MODE_NONE) runs with no idle cycles at all.
            idle_on = (phase != 2);
            foreach (key_pool[k]) key_pool[k] = $urandom;
            key_pool[POOL_SIZE-1] = phase[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;

            // Two phases fill the table and then try appends that must be refused.
            if (phase == 1 || phase == 4) begin
                while (key_count < DEPTH)
                    send_item(sols_pkg::CMD_APPEND, key_pool[$urandom_range(POOL_SIZE-1)],
                              1'b0, '0);
                repeat (2) send_item(sols_pkg::CMD_APPEND, $urandom, 1'b0, '0);
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 4) begin
                    send_item(CMD_SPARE, $urandom, 1'b0, '0);
                end else if (pick < 7) begin
                    send_item(sols_pkg::CMD_CLEAR, $urandom, 1'b0, '0);
                end else if (pick < 38) begin
                    key = ($urandom_range(9) < 7) ? key_pool[$urandom_range(POOL_SIZE-1)]
                                                  : $urandom;
                    send_item(sols_pkg::CMD_APPEND, key, 1'b0, '0);
                end else begin
                    if (key_count > 0 && $urandom_range(99) < 75) begin
                        if ($urandom_range(9) == 0)
                            key = key_table[key_count-1];
                        else
                            key = key_table[$urandom_range(key_count-1)];
                    end else if ($urandom_range(1) == 0) begin
                        key = key_pool[$urandom_range(POOL_SIZE-1)];
                    end else begin
                        key = $urandom;
                    end
                    send_item(sols_pkg::CMD_SEARCH, key, 1'b0, '0);
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && lookups_due.size() == 0) begin
            $display("tb_self_organizing_list_search: PASS");
        end else begin
            $display("tb_self_organizing_list_search: FAIL");
        end
        $finish;
    end

endmodule
